// File: design/gtbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gtbs_pkg;

    // table depths
    localparam int COMMON_DEPTH  = 4096;
    localparam int WEEKDAY_DEPTH = 8;
    localparam int CITY_DEPTH    = 256;

    localparam int COMMON_AW  = (COMMON_DEPTH  > 1) ? $clog2(COMMON_DEPTH)  : 1;
    localparam int WEEKDAY_AW = (WEEKDAY_DEPTH > 1) ? $clog2(WEEKDAY_DEPTH) : 1;
    localparam int CITY_AW    = (CITY_DEPTH    > 1) ? $clog2(CITY_DEPTH)    : 1;

    // the search engine spans the deepest table
    localparam int SRCH_DEPTH_A = (COMMON_DEPTH > CITY_DEPTH) ? COMMON_DEPTH : CITY_DEPTH;
    localparam int SRCH_DEPTH   = (SRCH_DEPTH_A > WEEKDAY_DEPTH) ? SRCH_DEPTH_A
                                                                 : WEEKDAY_DEPTH;
    localparam int SRCH_AW      = (SRCH_DEPTH > 1) ? $clog2(SRCH_DEPTH) : 1;
    localparam int CNT_W        = $clog2(SRCH_DEPTH + 1);

    // field widths
    localparam int ENTRY_W      = 16;
    localparam int KEY_W        = 21;
    localparam int IDX_W        = 12;
    localparam int PIX_W        = 8;
    localparam int SIZE_W       = 7;
    localparam int DEPTH_W      = 4;
    localparam int TID_W        = 2;
    localparam int SEL_W        = 2;
    localparam int BITS_PER_BYTE = 8;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_LARGE    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_MEDIUM   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_SMALL    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_TINY     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_DEPTH   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COMMON_COUNT  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WEEKDAY_COUNT = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CITY_COUNT    = 4'd7;

    // input kinds and load targets
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_LOAD   = 1'b1;

    localparam logic [TID_W-1:0] TBL_COMMON  = 2'd0;
    localparam logic [TID_W-1:0] TBL_WEEKDAY = 2'd1;
    localparam logic [TID_W-1:0] TBL_CITY    = 2'd2;

    // result tiers
    localparam logic [SEL_W-1:0] SEL_TINY    = 2'd0;
    localparam logic [SEL_W-1:0] SEL_SMALL   = 2'd1;
    localparam logic [SEL_W-1:0] SEL_WEEKDAY = 2'd2;
    localparam logic [SEL_W-1:0] SEL_CITY    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_DONE
    } srch_state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } srch_req_t;

    typedef struct packed {
        logic               valid;
        logic               found;
        logic [SRCH_AW-1:0] pos;
    } srch_res_t;

endpackage

`default_nettype wire

// File: design/gtbs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module gtbs_ram #(
    parameter  int WIDTH  = 16,
    parameter  int DEPTH  = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   aclk,
    input  wire logic                   wr_en,
    input  wire logic [ADDR_W-1:0]      wr_addr,
    input  wire logic [WIDTH-1:0]       wr_data,
    input  wire logic [ADDR_W-1:0]      rd_addr,
    output      logic [WIDTH-1:0]       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/gtbs_search.sv
`timescale 1ns / 1ps
`default_nettype none

module gtbs_search import gtbs_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire srch_req_t           req,
    input  wire logic [ENTRY_W-1:0]  rd_data,
    output      logic [SRCH_AW-1:0]  rd_addr,
    output      logic                idle,
    output      srch_res_t           res,
    input  wire logic                res_ack
);

    srch_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   end_reg, end_next;
    logic [SRCH_AW-1:0] mid_reg, mid_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               found_reg, found_next;

    logic [KEY_W-1:0]   entry;
    logic               hit;
    logic               below;
    logic [CNT_W-1:0]   lo_upd;
    logic [CNT_W-1:0]   end_upd;
    logic [CNT_W-1:0]   rng_lo;
    logic [CNT_W-1:0]   rng_end;
    logic [CNT_W-1:0]   span;
    logic [CNT_W-1:0]   mid_full;

    // compare the probed entry against the key; wide keys never match
    assign entry   = KEY_W'(rd_data);
    assign hit     = (entry == key_reg);
    assign below   = (entry < key_reg);
    assign lo_upd  = below ? (CNT_W'(mid_reg) + CNT_W'(1)) : lo_reg;
    assign end_upd = below ? end_reg : CNT_W'(mid_reg);

    // range for the next probe: fresh on start, narrowed while probing
    always_comb begin
        rng_lo  = lo_upd;
        rng_end = end_upd;
        if (state_reg == S_IDLE) begin
            rng_lo  = '0;
            rng_end = req.count;
        end
    end

    // midpoint rounding down over [lo, end-1]
    assign span     = rng_end - rng_lo - CNT_W'(1);
    assign mid_full = rng_lo + (span >> 1);
    assign rd_addr  = mid_full[SRCH_AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg  <= lo_next;
        end_reg <= end_next;
        mid_reg <= mid_next;
        key_reg <= key_next;
    end

    always_comb begin
        state_next = state_reg;
        found_next = found_reg;
        lo_next    = lo_reg;
        end_next   = end_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    key_next   = req.key;
                    lo_next    = rng_lo;
                    end_next   = rng_end;
                    mid_next   = rd_addr;
                    found_next = 1'b0;
                    state_next = (rng_end == '0) ? S_DONE : S_PROBE;
                end
            end
            S_PROBE: begin
                if (hit) begin
                    found_next = 1'b1;
                    state_next = S_DONE;
                end else begin
                    lo_next    = rng_lo;
                    end_next   = rng_end;
                    mid_next   = rd_addr;
                    state_next = (rng_lo < rng_end) ? S_PROBE : S_DONE;
                end
            end
            S_DONE: begin
                if (res_ack) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle      = (state_reg == S_IDLE);
    assign res.valid = (state_reg == S_DONE);
    assign res.found = found_reg;
    assign res.pos   = mid_reg;

    a_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE) |->
            (CNT_W'(mid_reg) >= lo_reg) && (CNT_W'(mid_reg) < end_reg))
        else $error("probe address outside search range");

    a_range_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE && !hit) |=>
            (state_reg != S_PROBE) || ((end_reg - lo_reg) < $past(end_reg - lo_reg)))
        else $error("search range failed to shrink");

    a_hit_reported: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE && hit) |=>
            (res.valid && res.found && res.pos == $past(mid_reg)))
        else $error("matching probe not reported");

endmodule

`default_nettype wire

// File: design/glyph_table_binary_search.sv
`timescale 1ns / 1ps
`default_nettype none

// Glyph table lookup by binary search. Three ascending 16-bit codepoint tables
// (common, weekday, city) sit in single-port-read synchronous RAMs and are filled
// by load words (s_tuser kind = 1); a load is written at its accept edge and
// gives no result. A lookup word picks a tier from its pixel size against the
// size thresholds, then searches the first <count> entries of that table, one
// probe per clock: the address of each probe is formed in the cycle that the
// previous RAM read data is compared, so the RAM read latency sets the loop. A
// lookup holds s_tready low through its p probes, p at most ceil(log2(count + 1))
// (13 for a full common table; none for an empty one), and until its result is
// taken into the output register. Results leave through an output register, so
// the next word is taken while a result still waits on m_tready; a further result
// that finds that register full holds the search, and s_tready, until m_tready
// drains it. Table contents are undefined until loaded, and the loaded part of a
// table is expected ascending. The user must write configuration through the
// cfg_ channel only while no lookup is in flight; the block does not enforce it.
// Counts larger than a table's depth are treated as the depth.

module glyph_table_binary_search import gtbs_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input stream
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    // [11:0] entry_index, [32:12] codepoint, [40:33] pixel_size, [47:41] zero
    input  wire logic [47:0]           s_tdata,
    // [0] kind, [2:1] table_id
    input  wire logic [2:0]            s_tuser,
    // result stream
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    // [11:0] glyph_index, [18:12] glyph_size, [25:19] stride bytes,
    // [29:26] pixel depth, [31:30] zero
    output      logic [31:0]           m_tdata,
    // [0] found, [2:1] table_select
    output      logic [2:0]            m_tuser,
    // configuration writes
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [SIZE_W-1:0]  size_large_reg;
    logic [SIZE_W-1:0]  size_medium_reg;
    logic [SIZE_W-1:0]  size_small_reg;
    logic [SIZE_W-1:0]  size_tiny_reg;
    logic [DEPTH_W-1:0] pixel_depth_reg;
    logic [12:0]        common_count_reg;
    logic [3:0]         weekday_count_reg;
    logic [8:0]         city_count_reg;

    logic cfg_we;

    // ready whenever out of reset: a write is registered at its accept edge
    assign cfg_ready = aresetn;
    assign cfg_we    = cfg_valid & cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_large_reg    <= SIZE_W'(30);
            size_medium_reg   <= SIZE_W'(26);
            size_small_reg    <= SIZE_W'(16);
            size_tiny_reg     <= SIZE_W'(10);
            pixel_depth_reg   <= DEPTH_W'(1);
            common_count_reg  <= '0;
            weekday_count_reg <= '0;
            city_count_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SIZE_LARGE:    size_large_reg    <= cfg_data[SIZE_W-1:0];
                REG_SIZE_MEDIUM:   size_medium_reg   <= cfg_data[SIZE_W-1:0];
                REG_SIZE_SMALL:    size_small_reg    <= cfg_data[SIZE_W-1:0];
                REG_SIZE_TINY:     size_tiny_reg     <= cfg_data[SIZE_W-1:0];
                REG_PIXEL_DEPTH:   pixel_depth_reg   <= cfg_data[DEPTH_W-1:0];
                REG_COMMON_COUNT:  common_count_reg  <= cfg_data[12:0];
                REG_WEEKDAY_COUNT: weekday_count_reg <= cfg_data[3:0];
                REG_CITY_COUNT:    city_count_reg    <= cfg_data[8:0];
                default: begin
                    // drop writes to unmapped indices
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Input word unpacking
    // ---------------------------------------------------------------------
    logic               in_kind;
    logic [TID_W-1:0]   in_table_id;
    logic [IDX_W-1:0]   in_entry_index;
    logic [KEY_W-1:0]   in_codepoint;
    logic [PIX_W-1:0]   in_pixel_size;
    logic               in_acc;
    logic               load_acc;
    logic               lookup_acc;
    logic               srch_idle;

    assign in_kind        = s_tuser[0];
    assign in_table_id    = s_tuser[2:1];
    assign in_entry_index = s_tdata[11:0];
    assign in_codepoint   = s_tdata[32:12];
    assign in_pixel_size  = s_tdata[40:33];

    // take words only out of reset and while no lookup is in flight
    assign s_tready   = aresetn & srch_idle;
    assign in_acc     = s_tvalid & s_tready;
    assign load_acc   = in_acc & (in_kind == KIND_LOAD);
    assign lookup_acc = in_acc & (in_kind == KIND_LOOKUP);

    // ---------------------------------------------------------------------
    // Table memories: loads write at the accept edge, the search reads
    // ---------------------------------------------------------------------
    logic [SRCH_AW-1:0] rd_addr;
    logic [ENTRY_W-1:0] common_rd_data;
    logic [ENTRY_W-1:0] weekday_rd_data;
    logic [ENTRY_W-1:0] city_rd_data;
    logic               common_we;
    logic               weekday_we;
    logic               city_we;

    // ignore loads to the spare target and beyond a table's depth
    assign common_we  = load_acc && (in_table_id == TBL_COMMON) &&
                        (32'(in_entry_index) < COMMON_DEPTH);
    assign weekday_we = load_acc && (in_table_id == TBL_WEEKDAY) &&
                        (32'(in_entry_index) < WEEKDAY_DEPTH);
    assign city_we    = load_acc && (in_table_id == TBL_CITY) &&
                        (32'(in_entry_index) < CITY_DEPTH);

    gtbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (COMMON_DEPTH)
    ) u_common_ram (
        .aclk    (aclk),
        .wr_en   (common_we),
        .wr_addr (COMMON_AW'(in_entry_index)),
        .wr_data (in_codepoint[ENTRY_W-1:0]),
        .rd_addr (COMMON_AW'(rd_addr)),
        .rd_data (common_rd_data)
    );

    gtbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WEEKDAY_DEPTH)
    ) u_weekday_ram (
        .aclk    (aclk),
        .wr_en   (weekday_we),
        .wr_addr (WEEKDAY_AW'(in_entry_index)),
        .wr_data (in_codepoint[ENTRY_W-1:0]),
        .rd_addr (WEEKDAY_AW'(rd_addr)),
        .rd_data (weekday_rd_data)
    );

    gtbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CITY_DEPTH)
    ) u_city_ram (
        .aclk    (aclk),
        .wr_en   (city_we),
        .wr_addr (CITY_AW'(in_entry_index)),
        .wr_data (in_codepoint[ENTRY_W-1:0]),
        .rd_addr (CITY_AW'(rd_addr)),
        .rd_data (city_rd_data)
    );

    // ---------------------------------------------------------------------
    // Tier selection from the requested size
    // ---------------------------------------------------------------------
    logic [SEL_W-1:0]  tier_sel;
    logic [SIZE_W-1:0] tier_size;
    logic [CNT_W-1:0]  common_n;
    logic [CNT_W-1:0]  weekday_n;
    logic [CNT_W-1:0]  city_n;
    srch_req_t         req;

    // saturate each count at its table depth
    assign common_n  = (32'(common_count_reg) > COMMON_DEPTH) ? CNT_W'(COMMON_DEPTH)
                                                              : CNT_W'(common_count_reg);
    assign weekday_n = (32'(weekday_count_reg) > WEEKDAY_DEPTH) ? CNT_W'(WEEKDAY_DEPTH)
                                                                : CNT_W'(weekday_count_reg);
    assign city_n    = (32'(city_count_reg) > CITY_DEPTH) ? CNT_W'(CITY_DEPTH)
                                                          : CNT_W'(city_count_reg);

    always_comb begin
        req.key = in_codepoint;
        priority if (in_pixel_size >= PIX_W'(size_large_reg)) begin
            tier_sel  = SEL_CITY;
            tier_size = size_large_reg;
            req.count = city_n;
        end else if (in_pixel_size >= PIX_W'(size_medium_reg)) begin
            tier_sel  = SEL_WEEKDAY;
            tier_size = size_medium_reg;
            req.count = weekday_n;
        end else if (in_pixel_size >= PIX_W'(size_small_reg)) begin
            tier_sel  = SEL_SMALL;
            tier_size = size_small_reg;
            req.count = common_n;
        end else begin
            tier_sel  = SEL_TINY;
            tier_size = size_tiny_reg;
            req.count = common_n;
        end
    end

    // hold the tier for the whole search
    logic [SEL_W-1:0]  sel_reg;
    logic [SIZE_W-1:0] size_reg;

    always_ff @(posedge aclk) begin
        if (lookup_acc) begin
            sel_reg  <= tier_sel;
            size_reg <= tier_size;
        end
    end

    // route the searched table's read data to the engine
    logic [ENTRY_W-1:0] srch_rd_data;

    always_comb begin
        unique case (sel_reg)
            SEL_TINY, SEL_SMALL: srch_rd_data = common_rd_data;
            SEL_WEEKDAY:         srch_rd_data = weekday_rd_data;
            SEL_CITY:            srch_rd_data = city_rd_data;
            default:             srch_rd_data = common_rd_data;
        endcase
    end

    // ---------------------------------------------------------------------
    // Search engine
    // ---------------------------------------------------------------------
    srch_res_t res;
    logic      res_ack;

    gtbs_search u_search (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lookup_acc),
        .req     (req),
        .rd_data (srch_rd_data),
        .rd_addr (rd_addr),
        .idle    (srch_idle),
        .res     (res),
        .res_ack (res_ack)
    );

    // ---------------------------------------------------------------------
    // Result word and output register
    // ---------------------------------------------------------------------
    logic [SIZE_W+DEPTH_W-1:0] row_bits;
    logic [SIZE_W+DEPTH_W-4:0] row_full;
    logic [SIZE_W-1:0]         stride;

    // size times depth over eight, saturate at the field's top
    assign row_bits = (SIZE_W+DEPTH_W)'(size_reg) * (SIZE_W+DEPTH_W)'(pixel_depth_reg);
    assign row_full = row_bits[SIZE_W+DEPTH_W-1:3];
    assign stride   = (row_full > (SIZE_W+DEPTH_W-3)'({SIZE_W{1'b1}})) ? {SIZE_W{1'b1}}
                                                                     : row_full[SIZE_W-1:0];

    logic               m_tvalid_reg;
    logic               found_reg;
    logic [SEL_W-1:0]   table_select_reg;
    logic [IDX_W-1:0]   glyph_index_reg;
    logic [SIZE_W-1:0]  glyph_size_reg;
    logic [SIZE_W-1:0]  stride_reg;
    logic [DEPTH_W-1:0] bpp_reg;

    // load the output register whenever it is empty or being drained
    assign res_ack = res.valid & (~m_tvalid_reg | m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ack) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ack) begin
            found_reg        <= res.found;
            table_select_reg <= sel_reg;
            glyph_index_reg  <= res.found ? IDX_W'(res.pos) : '0;
            glyph_size_reg   <= res.found ? size_reg : '0;
            stride_reg       <= res.found ? stride : '0;
            bpp_reg          <= pixel_depth_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, bpp_reg, stride_reg, glyph_size_reg, glyph_index_reg};
    assign m_tuser  = {table_select_reg, found_reg};

endmodule

`default_nettype wire
